// ===== rtl/core/tmb_pkg.sv =====
// Package for the transform matrix builder: shared types, constants, the CORDIC
// arctangent table and a rounding helper. No dependencies.
package tmb_pkg;

  localparam int ATAB_LEN = 24;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
  localparam logic signed [17:0] SAT_HI = 18'sd131071;
  localparam logic signed [17:0] SAT_LO = -18'sd131072;
  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

  typedef enum logic [2:0] {
    OP_ROTX = 3'd0,
    OP_ROTY = 3'd1,
    OP_ROTZ = 3'd2,
    OP_AXIS = 3'd3,
    OP_REFL = 3'd4,
    OP_INVL = 3'd5,
    OP_RSV6 = 3'd6,
    OP_RSV7 = 3'd7
  } op_t;

  typedef struct packed {
    logic        vld;
    op_t         op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } ctl_t;

  function automatic logic signed [33:0] atan_val(input int i);
    logic [31:0] v;
    begin
      case (i)
        0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
        3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
        6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
        9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
        12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
        15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
        18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
        21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      atan_val = $signed({2'b00, v});
    end
  endfunction

  // Round a value with sh + 14 fraction bits down to Q14 (half up) and saturate.
  function automatic logic signed [17:0] fin(input logic signed [79:0] v,
                                             input int sh);
    logic signed [79:0] r;
    begin
      r = (v + (80'sd1 <<< (sh - 1))) >>> sh;
      if (r > 80'(SAT_HI)) fin = SAT_HI;
      else if (r < 80'(SAT_LO)) fin = SAT_LO;
      else fin = r[17:0];
    end
  endfunction

endpackage

// ===== rtl/core/tmb_phase.sv =====
// Angle reduction stages: degrees modulo 360 to a binary phase with half-turn fold.
// Five register stages, reciprocal multiplications only. No dependencies.
module tmb_phase (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [31:0]  angle_deg,
  output logic                out_vld,
  output logic signed [33:0]  z,
  output logic                neg
);

  // The integer degrees are shifted by 92 turns so the high half is never negative.
  localparam logic [17:0] HI_OFFS   = 18'd33120;
  // ceil(2^26/360): exact quotient for the high half, which stays below 2^17.
  localparam logic [17:0] RECIP_360 = 18'd186414;
  // ceil(2^31/45): exact quotient for a reduced angle below 360*2^16.
  localparam logic [25:0] RECIP_45  = 26'd47721859;
  // ceil(2^30/45): exact floor(r*2^13/45) for a remainder r below 45.
  localparam logic [24:0] RECIP_45F = 25'd23860930;

  logic               v1, v2, v3, v4, v5;
  logic [16:0]        h1;
  logic [15:0]        lo1;
  logic [7:0]         hq1;
  logic [24:0]        a2, a3;
  logic [18:0]        qa3, qa4;
  logic [5:0]         ra4;

  logic [17:0]        h_c;
  logic [34:0]        hp;
  logic [16:0]        hm;
  logic [49:0]        qp;
  logic [25:0]        rf;
  logic [29:0]        fp;
  logic [31:0]        q;
  logic signed [33:0] zz;

  // The angle is hi*2^16 + lo, so the reduced angle is (hi mod 360)*2^16 + lo.
  // The phase floor(a*2^16/360) equals floor(a/45)*2^13 + floor((a mod 45)*2^13/45).
  always_comb begin
    h_c = 18'($signed(angle_deg[31:16])) + HI_OFFS;
    hp  = 35'(h_c[16:0]) * 35'(RECIP_360);
    hm  = h1 - 17'(hq1) * 17'd360;
    qp  = 50'(a2) * 50'(RECIP_45);
    rf  = 26'(a3) - 26'(qa3) * 26'd45;
    fp  = 30'(ra4) * 30'(RECIP_45F);
    q   = {qa4, fp[29:17]};
    zz  = 34'($signed(q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      v1 <= in_vld; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
    h1  <= h_c[16:0];
    lo1 <= angle_deg[15:0];
    hq1 <= hp[33:26];
    a2  <= {hm[8:0], lo1};
    a3  <= a2;
    qa3 <= qp[49:31];
    qa4 <= qa3;
    ra4 <= rf[5:0];
    if (zz > 34'sd1073741824) begin
      z <= zz - 34'sd2147483648; neg <= 1'b1;
    end else if (zz < -34'sd1073741824) begin
      z <= zz + 34'sd2147483648; neg <= 1'b1;
    end else begin
      z <= zz; neg <= 1'b0;
    end
  end
  assign out_vld = v5;

endmodule

// ===== rtl/core/tmb_cordic.sv =====
// Pipelined rotation-mode CORDIC, one register stage per iteration.
// Uses tmb_pkg for the gain and arctangent table.
module tmb_cordic #(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [33:0]  z_in,
  input  logic                neg_in,
  output logic                out_vld,
  output logic signed [33:0]  cos_o,
  output logic signed [33:0]  sin_o
);

  localparam int N = (STEPS > tmb_pkg::ATAB_LEN) ? tmb_pkg::ATAB_LEN : STEPS;

  logic               v [N+1];
  logic               ng[N+1];
  logic signed [33:0] x [N+1];
  logic signed [33:0] y [N+1];
  logic signed [33:0] zr[N+1];

  assign v[0]  = in_vld;
  assign ng[0] = neg_in;
  assign x[0]  = 34'($signed({2'b00, tmb_pkg::CORDIC_GAIN}));
  assign y[0]  = '0;
  assign zr[0] = z_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      ng[i+1] <= ng[i];
      if (!zr[i][33]) begin
        x[i+1]  <= x[i] - (y[i] >>> i);
        y[i+1]  <= y[i] + (x[i] >>> i);
        zr[i+1] <= zr[i] - tmb_pkg::atan_val(i);
      end else begin
        x[i+1]  <= x[i] + (y[i] >>> i);
        y[i+1]  <= y[i] - (x[i] >>> i);
        zr[i+1] <= zr[i] + tmb_pkg::atan_val(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= v[N];
    cos_o <= ng[N] ? -x[N] : x[N];
    sin_o <= ng[N] ? -y[N] : y[N];
  end

endmodule

// ===== rtl/core/tmb_matrix.sv =====
// Matrix assembly: products, sums, rounding and saturation over three stages.
// Uses tmb_pkg.
module tmb_matrix (
  input  logic                clk,
  input  logic                rst,
  input  tmb_pkg::ctl_t       ctl,
  input  logic signed [33:0]  c,
  input  logic signed [33:0]  s,
  output logic                vld,
  output logic signed [17:0]  m [9]
);

  // Stage A: axis products and c/s scaling.
  tmb_pkg::ctl_t      ca, cb;
  logic signed [31:0] pp [9];   // ai*aj
  logic signed [49:0] sa_x, sa_y, sa_z;
  logic signed [34:0] omc;
  logic signed [33:0] ca_c, ca_s, cb_c;
  logic signed [79:0] t [9];
  logic signed [79:0] t_next [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      ca.vld <= 1'b0; cb.vld <= 1'b0; vld <= 1'b0;
    end else begin
      ca.vld <= ctl.vld; cb.vld <= ca.vld; vld <= cb.vld;
    end
    ca.op <= ctl.op; ca.ax <= ctl.ax; ca.ay <= ctl.ay; ca.az <= ctl.az;
    pp[0] <= ctl.ax * ctl.ax; pp[1] <= ctl.ax * ctl.ay; pp[2] <= ctl.ax * ctl.az;
    pp[3] <= ctl.ax * ctl.ay; pp[4] <= ctl.ay * ctl.ay; pp[5] <= ctl.ay * ctl.az;
    pp[6] <= ctl.ax * ctl.az; pp[7] <= ctl.ay * ctl.az; pp[8] <= ctl.az * ctl.az;
    sa_x <= s * ctl.ax; sa_y <= s * ctl.ay; sa_z <= s * ctl.az;
    omc  <= 35'sd1073741824 - 35'(c);
    ca_c <= c; ca_s <= s;
  end

  // Stage B: per-entry unrounded value.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      case (ca.op)
        tmb_pkg::OP_AXIS: t_next[i] = 80'(omc) * 80'(pp[i]);
        tmb_pkg::OP_REFL: t_next[i] = -(80'(pp[i]) <<< 1);
        tmb_pkg::OP_INVL: t_next[i] = (80'(pp[i]) <<< 1);
        default: t_next[i] = '0;
      endcase
    end
    case (ca.op)
      tmb_pkg::OP_ROTX: begin
        t_next[0] = 80'sd1 <<< 30; t_next[4] = 80'(ca_c); t_next[5] = -80'(ca_s);
        t_next[7] = 80'(ca_s); t_next[8] = 80'(ca_c);
      end
      tmb_pkg::OP_ROTY: begin
        t_next[0] = 80'(ca_c); t_next[2] = 80'(ca_s); t_next[4] = 80'sd1 <<< 30;
        t_next[6] = -80'(ca_s); t_next[8] = 80'(ca_c);
      end
      tmb_pkg::OP_ROTZ: begin
        t_next[0] = 80'(ca_c); t_next[1] = -80'(ca_s); t_next[3] = 80'(ca_s);
        t_next[4] = 80'(ca_c); t_next[8] = 80'sd1 <<< 30;
      end
      tmb_pkg::OP_AXIS: begin
        t_next[1] = t_next[1] - (80'(sa_z) <<< 14);
        t_next[3] = t_next[3] + (80'(sa_z) <<< 14);
        t_next[2] = t_next[2] + (80'(sa_y) <<< 14);
        t_next[6] = t_next[6] - (80'(sa_y) <<< 14);
        t_next[5] = t_next[5] - (80'(sa_x) <<< 14);
        t_next[7] = t_next[7] + (80'(sa_x) <<< 14);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cb.op <= ca.op; cb.ax <= ca.ax; cb.ay <= ca.ay; cb.az <= ca.az;
    cb_c <= ca_c;
    for (int i = 0; i < 9; i++) t[i] <= t_next[i];
  end

  // Stage C: diagonal term, rounding and saturation.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      case (cb.op)
        tmb_pkg::OP_ROTX, tmb_pkg::OP_ROTY, tmb_pkg::OP_ROTZ:
          m[i] <= tmb_pkg::fin(t[i], 16);
        tmb_pkg::OP_AXIS:
          m[i] <= tmb_pkg::fin(t[i] + ((i % 4 == 0) ? (80'(cb_c) <<< 28) : 80'sd0), 44);
        tmb_pkg::OP_REFL:
          m[i] <= tmb_pkg::fin(t[i] + ((i % 4 == 0) ? (80'sd1 <<< 28) : 80'sd0), 14);
        tmb_pkg::OP_INVL:
          m[i] <= tmb_pkg::fin(t[i] - ((i % 4 == 0) ? (80'sd1 <<< 28) : 80'sd0), 14);
        default:
          m[i] <= (i % 4 == 0) ? tmb_pkg::ONE_Q14 : 18'sd0;
      endcase
    end
  end

endmodule

// ===== rtl/core/transform_matrix_builder.sv =====
// Top level of the transform matrix builder: angle reduction, CORDIC and matrix
// assembly pipeline. Depends on tmb_pkg, tmb_phase, tmb_cordic and tmb_matrix.
//
//   channel   ports                                   handshake
//   request   op, angle_deg, axis_x, axis_y, axis_z   start (taken when busy is low)
//   result    m00 .. m22                              done, one cycle, no back-pressure
//
// One request is taken every cycle; the result passes through five reduction stages,
// the CORDIC_STEPS iterations (steps capped at 24) plus its output register, and
// three matrix stages. Reset clears only the valid bits. busy stays low: the receiver
// cannot stall, so the pipeline never needs to hold.
module transform_matrix_builder #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic signed [31:0] angle_deg,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic               done,
  output logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  localparam int N = (CORDIC_STEPS > tmb_pkg::ATAB_LEN) ? tmb_pkg::ATAB_LEN : CORDIC_STEPS;
  localparam int DLY = N + 6;   // phase (5) + CORDIC (N + 1)

  logic               ph_vld, ph_neg, co_vld;
  logic signed [33:0] ph_z, co_c, co_s;
  logic signed [17:0] m [9];
  tmb_pkg::ctl_t      line [DLY+1];

  assign busy = 1'b0;

  // Request fields travel beside the angle path in a delay line.
  assign line[0] = '{vld: start, op: tmb_pkg::op_t'(op), ax: axis_x, ay: axis_y, az: axis_z};
  for (genvar i = 0; i < DLY; i++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) line[i+1].vld <= 1'b0;
      else line[i+1].vld <= line[i].vld;
      line[i+1].op <= line[i].op;
      line[i+1].ax <= line[i].ax;
      line[i+1].ay <= line[i].ay;
      line[i+1].az <= line[i].az;
    end
  end

  tmb_phase u_phase (
    .clk(clk), .rst(rst), .in_vld(start), .angle_deg(angle_deg),
    .out_vld(ph_vld), .z(ph_z), .neg(ph_neg)
  );

  tmb_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .in_vld(ph_vld), .z_in(ph_z), .neg_in(ph_neg),
    .out_vld(co_vld), .cos_o(co_c), .sin_o(co_s)
  );

  tmb_matrix u_matrix (
    .clk(clk), .rst(rst), .ctl('{vld: line[DLY].vld & co_vld, op: line[DLY].op,
    ax: line[DLY].ax, ay: line[DLY].ay, az: line[DLY].az}),
    .c(co_c), .s(co_s), .vld(done), .m(m)
  );

  assign m00 = m[0]; assign m01 = m[1]; assign m02 = m[2];
  assign m10 = m[3]; assign m11 = m[4]; assign m12 = m[5];
  assign m20 = m[6]; assign m21 = m[7]; assign m22 = m[8];

endmodule

// ===== verif/tb_transform_matrix_builder.sv =====
// Testbench for transform_matrix_builder: drives matrix requests and checks each
// result word against a built-in fixed-point predictor. Depends on tmb_pkg and the RTL.
`timescale 1ns / 100ps

module tb_transform_matrix_builder;

  localparam int STEPS = 16;
  localparam int LATENCY = ((STEPS > 24) ? 24 : STEPS) + 9;
  localparam longint DEG_TURN = 64'sd360 * 65536;

  typedef struct {
    logic signed [17:0] m [9];
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] op = tmb_pkg::OP_ROTX;
  logic signed [31:0] angle_deg = '0;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic done;
  logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  // Matrices still owed by the block, oldest first.
  matrix_t pending_matrices[$];
  int errors = 0;
  bit allow_gaps = 1'b1;

  transform_matrix_builder #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .angle_deg(angle_deg), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .done(done), .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
    .m12(m12), .m20(m20), .m21(m21), .m22(m22)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arbitrary-precision values are not needed: every term fits in 64 bits.
  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic logic signed [17:0] round_sat(longint v, int sh);
    longint r;
    r = floor_shift(v + (64'sd1 <<< (sh - 1)), sh);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  // Angle reduction, half-turn folding and rotation-mode CORDIC, all in Q1.30.
  task automatic cordic_sin_cos(input longint deg, output longint c, output longint s);
    longint a, z, x, y, t, at;
    bit flip;
    flip = 1'b0;
    a = deg % DEG_TURN;
    if (a < 0) a += DEG_TURN;
    z = (a * 65536) / 360;
    if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31);
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31);
      flip = 1'b1;
    end
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      case (i)
        0: at = 'h20000000;  1: at = 'h12E4051E;  2: at = 'h09FB385B;
        3: at = 'h051111D4;  4: at = 'h028B0D43;  5: at = 'h0145D7E1;
        6: at = 'h00A2F61E;  7: at = 'h00517C55;  8: at = 'h0028BE53;
        9: at = 'h00145F2F;  10: at = 'h000A2F98; 11: at = 'h000517CC;
        12: at = 'h00028BE6; 13: at = 'h000145F3; 14: at = 'h0000A2FA;
        15: at = 'h0000517D; 16: at = 'h000028BE; 17: at = 'h0000145F;
        18: at = 'h00000A30; 19: at = 'h00000518; 20: at = 'h0000028C;
        21: at = 'h00000146; 22: at = 'h000000A3; default: at = 'h00000051;
      endcase
      if (z >= 0) begin
        t = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= at;
      end else begin
        t = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += at;
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_matrix(input logic [2:0] code, input logic signed [31:0] deg,
                                input logic signed [15:0] vx, vy, vz,
                                output matrix_t res);
    longint c, s, one, omc, c58, sx, sy, sz, xy, xz, yz, k, d;
    longint v [3];
    longint raw [9];
    c = 0;
    s = 0;
    one = 64'sd1 <<< 30;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    if (code <= tmb_pkg::OP_AXIS) cordic_sin_cos(deg, c, s);
    case (code)
      tmb_pkg::OP_ROTX, tmb_pkg::OP_ROTY, tmb_pkg::OP_ROTZ: begin
        for (int i = 0; i < 9; i++) raw[i] = 0;
        if (code == tmb_pkg::OP_ROTX) begin
          raw[0] = one; raw[4] = c; raw[5] = -s; raw[7] = s; raw[8] = c;
        end else if (code == tmb_pkg::OP_ROTY) begin
          raw[0] = c; raw[2] = s; raw[4] = one; raw[6] = -s; raw[8] = c;
        end else begin
          raw[0] = c; raw[1] = -s; raw[3] = s; raw[4] = c; raw[8] = one;
        end
        for (int i = 0; i < 9; i++) res.m[i] = round_sat(raw[i], 16);
      end
      tmb_pkg::OP_AXIS: begin
        // Rodrigues form in Q58.
        omc = one - c;
        c58 = c * (64'sd1 <<< 28);
        sx = s * v[0] * 16384;
        sy = s * v[1] * 16384;
        sz = s * v[2] * 16384;
        xy = omc * (v[0] * v[1]);
        xz = omc * (v[0] * v[2]);
        yz = omc * (v[1] * v[2]);
        raw[0] = c58 + omc * (v[0] * v[0]); raw[1] = xy - sz; raw[2] = xz + sy;
        raw[3] = xy + sz; raw[4] = c58 + omc * (v[1] * v[1]); raw[5] = yz - sx;
        raw[6] = xz - sy; raw[7] = yz + sx; raw[8] = c58 + omc * (v[2] * v[2]);
        for (int i = 0; i < 9; i++) res.m[i] = round_sat(raw[i], 44);
      end
      tmb_pkg::OP_REFL, tmb_pkg::OP_INVL: begin
        k = (code == tmb_pkg::OP_REFL) ? -2 : 2;
        d = (code == tmb_pkg::OP_REFL) ? (64'sd1 <<< 28) : -(64'sd1 <<< 28);
        for (int r = 0; r < 3; r++)
          for (int q = 0; q < 3; q++)
            res.m[r*3+q] = round_sat(k * v[r] * v[q] + ((r == q) ? d : 0), 14);
      end
      default: begin
        for (int i = 0; i < 9; i++) res.m[i] = (i % 4 == 0) ? 18'sd16384 : 18'sd0;
      end
    endcase
  endtask

  // Sends one word; the word is taken at the edge where start is high and busy low.
  task automatic send_request(input logic [2:0] code, input logic signed [31:0] deg,
                              input logic signed [15:0] vx, vy, vz);
    matrix_t exp_m;
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= code;
    angle_deg <= deg;
    axis_x <= vx;
    axis_y <= vy;
    axis_z <= vz;
    predict_matrix(code, deg, vx, vy, vz, exp_m);
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_matrices.push_back(exp_m);
  endtask

  task automatic idle_line();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker: done is sampled at the edge, after the block's outputs settled.
  always @(posedge clk) begin
    matrix_t exp_m;
    logic signed [17:0] got [9];
    if (!rst && done) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      if (pending_matrices.size() == 0) begin
        $display("%0t: unexpected result word, m00=%0d", $time, m00);
        errors++;
      end else begin
        exp_m = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_m.m[i]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                     exp_m.m[i], got[i]);
            errors++;
          end
      end
    end
  end

  function automatic logic signed [15:0] rand_unit_ish();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom_range(0, 65535));
      default: return $signed(16'($urandom_range(0, 23170))) - 16'sd11585;
    endcase
  endfunction

  task automatic test_axis_rotations();
    logic signed [31:0] angles [8];
    angles = '{32'sd0, 32'sd90 <<< 16, 32'sd180 <<< 16, 32'sd270 <<< 16,
               -(32'sd45 <<< 16), 32'h7FFFFFFF, 32'h80000000, 32'sd360 <<< 16};
    for (int i = 0; i < 8; i++)
      send_request(tmb_pkg::op_t'(i % 3), angles[i], 16'sh7FFF, 16'sh8000, 16'sd1);
  endtask

  task automatic test_rodrigues();
    send_request(tmb_pkg::OP_AXIS, 32'sd30 <<< 16, 16'sd16384, 16'sd0, 16'sd0);
    send_request(tmb_pkg::OP_AXIS, 32'sd123 <<< 16, 16'sd9459, 16'sd9459, 16'sd9459);
    // Axis far from unit length drives entries into saturation.
    send_request(tmb_pkg::OP_AXIS, 32'sd200 <<< 16, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_request(tmb_pkg::OP_AXIS, 32'h80000000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
  endtask

  task automatic test_reflect_involute();
    send_request(tmb_pkg::OP_REFL, 32'h12345678, 16'sd0, 16'sd16384, 16'sd0);
    send_request(tmb_pkg::OP_REFL, 32'sd0, 16'sh8000, 16'sd0, 16'sd0);
    send_request(tmb_pkg::OP_INVL, 32'sd0, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_request(tmb_pkg::OP_INVL, 32'hFFFFFFFF, 16'sd9459, -16'sd9459, 16'sd9459);
  endtask

  task automatic test_reserved_ops();
    send_request(tmb_pkg::OP_RSV6, 32'sd77 <<< 16, 16'sd5, 16'sd6, 16'sd7);
    send_request(tmb_pkg::OP_RSV7, 32'h80000000, 16'sh8000, 16'sh7FFF, 16'sd0);
  endtask

  // The sender holds off until every matrix owed has come back.
  task automatic test_drain_pause();
    idle_line();
    while (pending_matrices.size() != 0) @(posedge clk);
    send_request(tmb_pkg::OP_ROTZ, 32'sd60 <<< 16, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_random(input int count);
    logic [2:0] code;
    logic signed [31:0] deg;
    for (int n = 0; n < count; n++) begin
      code = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      deg = ($urandom_range(0, 1) == 0) ? $urandom()
                                        : $signed(32'($urandom_range(0, 720 * 65536)))
                                          - 32'sd23592960;
      send_request(code, deg, rand_unit_ish(), rand_unit_ish(), rand_unit_ish());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_axis_rotations();
    test_rodrigues();
    test_reflect_involute();
    test_reserved_ops();
    test_drain_pause();
    test_random(1150);
    allow_gaps = 1'b0;
    test_random(280);
    idle_line();
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
